// ===== hdl/vpa_pkg.sv =====
// Shared constants, codes and types of the variable partition allocator.
package vpa_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W     = 24;
  localparam int OWNER_W    = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [ADDR_W-1:0] DEFAULT_TOTAL = ADDR_W'(1048576);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = CFG_IDX_W'(1);

  // fit strategies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;
  localparam logic [1:0] FIT_NEXT  = 2'd3;

  // operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_NOFIT = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  size;
    logic               free;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_MOD, ST_SRD, ST_SEV, ST_DEC, ST_HRD, ST_HWR,
    ST_WSPL, ST_WOWN, ST_FRD, ST_FEV, ST_FEND
  } state_t;

endpackage

// ===== hdl/variable_partition_allocator.sv =====
// Variable partition allocator: one item at a time.
// Zero request: answered with no fit straight from idle. Allocate: scan entries, then where needed
// shift entries and write the split, then write the owner entry; next fit first reduces the start modulo the count.
// Free: walk every table entry, then write the last merged entry. A new item can be taken while done is shown.
// Reset (synchronous) and a total size write rebuild the table.
// The result beat is shown for one cycle on done; the receiver cannot stall.
module variable_partition_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vpa_pkg::ADDR_W-1:0]      cfg_data,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [vpa_pkg::OWNER_W-1:0]     owner_id,
  input  logic [vpa_pkg::ADDR_W-1:0]      request_size,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [vpa_pkg::IDX_W-1:0]       block_index,
  output logic [vpa_pkg::ADDR_W-1:0]      start_address
);

  logic [1:0]                  fit;
  logic [vpa_pkg::ADDR_W-1:0]  total;
  logic                        reinit;
  logic                        ram_we;
  logic [vpa_pkg::IDX_W-1:0]   ram_waddr;
  logic [vpa_pkg::IDX_W-1:0]   ram_raddr;
  vpa_pkg::entry_t             ram_wdata;
  vpa_pkg::entry_t             ram_rdata;

  assign reinit = cfg_we && (cfg_index == vpa_pkg::CFG_TOTAL);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit   <= vpa_pkg::FIT_FIRST;
      total <= vpa_pkg::DEFAULT_TOTAL;
    end else if (cfg_we) begin
      if (cfg_index == vpa_pkg::CFG_FIT) begin
        fit <= cfg_data[1:0];
      end else if (cfg_index == vpa_pkg::CFG_TOTAL) begin
        total <= cfg_data;
      end
    end
  end

  vpa_ram #(
    .WIDTH (vpa_pkg::ENTRY_W),
    .DEPTH (vpa_pkg::MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vpa_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .reinit        (reinit),
    .fit           (fit),
    .total         (total),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .owner_id      (owner_id),
    .request_size  (request_size),
    .done          (done),
    .status        (status),
    .block_index   (block_index),
    .start_address (start_address),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

endmodule

// ===== hdl/vpa_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module vpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/vpa_engine.sv =====
// Sequencer that searches, splits, shifts and merges the block table in RAM.
module vpa_engine (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            reinit,
  input  logic [1:0]                      fit,
  input  logic [vpa_pkg::ADDR_W-1:0]      total,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [vpa_pkg::OWNER_W-1:0]     owner_id,
  input  logic [vpa_pkg::ADDR_W-1:0]      request_size,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [vpa_pkg::IDX_W-1:0]       block_index,
  output logic [vpa_pkg::ADDR_W-1:0]      start_address,
  output logic                            ram_we,
  output logic [vpa_pkg::IDX_W-1:0]       ram_waddr,
  output vpa_pkg::entry_t                 ram_wdata,
  output logic [vpa_pkg::IDX_W-1:0]       ram_raddr,
  input  vpa_pkg::entry_t                 ram_rdata
);

  vpa_pkg::state_t                   state, state_next;
  logic [vpa_pkg::CNT_W-1:0]         cnt, cnt_next;
  logic [vpa_pkg::IDX_W-1:0]         nfp, nfp_next;
  logic [vpa_pkg::IDX_W-1:0]         pos, pos_next;
  logic [vpa_pkg::CNT_W-1:0]         k, k_next;
  logic [vpa_pkg::CNT_W-1:0]         j, j_next;
  logic [vpa_pkg::CNT_W-1:0]         n, n_next;
  logic                              found, found_next;
  logic [vpa_pkg::IDX_W-1:0]         pick, pick_next;
  vpa_pkg::entry_t                   pent, pent_next;
  vpa_pkg::entry_t                   acc, acc_next;
  logic [vpa_pkg::OWNER_W-1:0]       own, own_next;
  logic [vpa_pkg::ADDR_W-1:0]        req, req_next;
  logic                              done_next;
  logic [1:0]                        status_next;
  logic [vpa_pkg::IDX_W-1:0]         block_index_next;
  logic [vpa_pkg::ADDR_W-1:0]        start_address_next;
  vpa_pkg::entry_t                   e;
  logic                              hit, better, last;

  assign busy = (state != vpa_pkg::ST_IDLE);

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vpa_pkg::ST_INIT;
      cnt   <= vpa_pkg::CNT_W'(1);
      nfp   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      nfp   <= nfp_next;
      done  <= done_next;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    pos           <= pos_next;
    k             <= k_next;
    j             <= j_next;
    n             <= n_next;
    found         <= found_next;
    pick          <= pick_next;
    pent          <= pent_next;
    acc           <= acc_next;
    own           <= own_next;
    req           <= req_next;
    status        <= status_next;
    block_index   <= block_index_next;
    start_address <= start_address_next;
  end

  // next state, RAM access and results
  always_comb begin
    state_next         = state;
    cnt_next           = cnt;
    nfp_next           = nfp;
    pos_next           = pos;
    k_next             = k;
    j_next             = j;
    n_next             = n;
    found_next         = found;
    pick_next          = pick;
    pent_next          = pent;
    acc_next           = acc;
    own_next           = own;
    req_next           = req;
    done_next          = 1'b0;
    status_next        = status;
    block_index_next   = block_index;
    start_address_next = start_address;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_wdata          = '0;
    ram_raddr          = pos;
    e                  = ram_rdata;
    hit                = e.free && (e.size >= req);
    better             = !found ||
                         (fit == vpa_pkg::FIT_BEST  && e.size < pent.size) ||
                         (fit == vpa_pkg::FIT_WORST && e.size > pent.size);
    last               = (({1'b0, pos} + vpa_pkg::CNT_W'(1)) == cnt);

    unique case (state)
      vpa_pkg::ST_INIT: begin
        ram_we         = 1'b1;
        ram_waddr      = '0;
        ram_wdata.base = '0;
        ram_wdata.size = total;
        ram_wdata.free = 1'b1;
        cnt_next       = vpa_pkg::CNT_W'(1);
        nfp_next       = '0;
        state_next     = vpa_pkg::ST_IDLE;
      end
      vpa_pkg::ST_IDLE: begin
        if (start) begin
          own_next   = owner_id;
          req_next   = request_size;
          found_next = 1'b0;
          k_next     = '0;
          n_next     = '0;
          pos_next   = '0;
          if (operation == vpa_pkg::OP_FREE) begin
            state_next = vpa_pkg::ST_FRD;
          end else if (request_size == '0) begin
            done_next          = 1'b1;
            status_next        = vpa_pkg::STAT_NOFIT;
            block_index_next   = '0;
            start_address_next = '0;
          end else if (fit == vpa_pkg::FIT_NEXT) begin
            pos_next   = nfp;
            state_next = vpa_pkg::ST_MOD;
          end else begin
            state_next = vpa_pkg::ST_SRD;
          end
        end
      end
      // reduce the next fit start modulo the entry count
      vpa_pkg::ST_MOD: begin
        if ({1'b0, pos} >= cnt) begin
          pos_next = vpa_pkg::IDX_W'({1'b0, pos} - cnt);
        end else begin
          state_next = vpa_pkg::ST_SRD;
        end
      end
      vpa_pkg::ST_SRD: begin
        state_next = vpa_pkg::ST_SEV;
      end
      // check one entry against the request
      vpa_pkg::ST_SEV: begin
        if (hit && better) begin
          found_next = 1'b1;
          pick_next  = pos;
          pent_next  = e;
        end
        k_next = k + vpa_pkg::CNT_W'(1);
        if (hit && (fit == vpa_pkg::FIT_FIRST || fit == vpa_pkg::FIT_NEXT)) begin
          state_next = vpa_pkg::ST_DEC;
        end else if ((k + vpa_pkg::CNT_W'(1)) == cnt) begin
          state_next = vpa_pkg::ST_DEC;
        end else begin
          pos_next   = last ? '0 : pos + vpa_pkg::IDX_W'(1);
          state_next = vpa_pkg::ST_SRD;
        end
      end
      vpa_pkg::ST_DEC: begin
        j_next = cnt;
        if (!found) begin
          done_next          = 1'b1;
          status_next        = vpa_pkg::STAT_NOFIT;
          block_index_next   = '0;
          start_address_next = '0;
          state_next         = vpa_pkg::ST_IDLE;
        end else if (pent.size == req) begin
          state_next = vpa_pkg::ST_WOWN;
        end else if (cnt == vpa_pkg::CNT_W'(vpa_pkg::MAX_BLOCKS)) begin
          done_next          = 1'b1;
          status_next        = vpa_pkg::STAT_FULL;
          block_index_next   = '0;
          start_address_next = '0;
          state_next         = vpa_pkg::ST_IDLE;
        end else if (cnt > ({1'b0, pick} + vpa_pkg::CNT_W'(1))) begin
          state_next = vpa_pkg::ST_HRD;
        end else begin
          state_next = vpa_pkg::ST_WSPL;
        end
      end
      // move entries up by one to open a slot after the pick
      vpa_pkg::ST_HRD: begin
        ram_raddr  = vpa_pkg::IDX_W'(j - vpa_pkg::CNT_W'(1));
        state_next = vpa_pkg::ST_HWR;
      end
      vpa_pkg::ST_HWR: begin
        ram_we     = 1'b1;
        ram_waddr  = j[vpa_pkg::IDX_W-1:0];
        ram_wdata  = e;
        j_next     = j - vpa_pkg::CNT_W'(1);
        if ((j - vpa_pkg::CNT_W'(1)) > ({1'b0, pick} + vpa_pkg::CNT_W'(1))) begin
          state_next = vpa_pkg::ST_HRD;
        end else begin
          state_next = vpa_pkg::ST_WSPL;
        end
      end
      vpa_pkg::ST_WSPL: begin
        ram_we          = 1'b1;
        ram_waddr       = pick + vpa_pkg::IDX_W'(1);
        ram_wdata.base  = pent.base + req;
        ram_wdata.size  = pent.size - req;
        ram_wdata.free  = 1'b1;
        ram_wdata.owner = '0;
        cnt_next        = cnt + vpa_pkg::CNT_W'(1);
        state_next      = vpa_pkg::ST_WOWN;
      end
      vpa_pkg::ST_WOWN: begin
        ram_we          = 1'b1;
        ram_waddr       = pick;
        ram_wdata.base  = pent.base;
        ram_wdata.size  = req;
        ram_wdata.free  = 1'b0;
        ram_wdata.owner = own;
        if (fit == vpa_pkg::FIT_NEXT) begin
          nfp_next = pick;
        end
        done_next          = 1'b1;
        status_next        = vpa_pkg::STAT_OK;
        block_index_next   = pick;
        start_address_next = pent.base;
        state_next         = vpa_pkg::ST_IDLE;
      end
      vpa_pkg::ST_FRD: begin
        state_next = vpa_pkg::ST_FEV;
      end
      // release owner entries and fold free runs, writing behind the read
      vpa_pkg::ST_FEV: begin
        if (!e.free && e.owner == own) begin
          e.free = 1'b1;
        end
        if (n != '0 && acc.free && e.free) begin
          acc_next.size = acc.size + e.size;
        end else begin
          if (n != '0) begin
            ram_we    = 1'b1;
            ram_waddr = vpa_pkg::IDX_W'(n - vpa_pkg::CNT_W'(1));
            ram_wdata = acc;
          end
          acc_next = e;
          n_next   = n + vpa_pkg::CNT_W'(1);
        end
        pos_next   = pos + vpa_pkg::IDX_W'(1);
        state_next = last ? vpa_pkg::ST_FEND : vpa_pkg::ST_FRD;
      end
      vpa_pkg::ST_FEND: begin
        ram_we             = 1'b1;
        ram_waddr          = vpa_pkg::IDX_W'(n - vpa_pkg::CNT_W'(1));
        ram_wdata          = acc;
        cnt_next           = n;
        done_next          = 1'b1;
        status_next        = vpa_pkg::STAT_OK;
        block_index_next   = '0;
        start_address_next = '0;
        state_next         = vpa_pkg::ST_IDLE;
      end
      default: begin
        state_next = vpa_pkg::ST_INIT;
      end
    endcase

    // a size write rebuilds the table
    if (reinit) begin
      state_next = vpa_pkg::ST_INIT;
    end
  end

endmodule
